@@ rtl/core/tcpq_pkg.sv @@
// shared types and constants for the two-class priority queue
`default_nettype none

package tcpq_pkg;

  localparam int unsigned PERSON_ID_W = 16;
  localparam int unsigned COUNT_W     = 5;

  typedef enum logic [1:0] {
    REQ_INSERT       = 2'd0,
    REQ_SERVE_PREF   = 2'd1,
    REQ_SERVE_OLDEST = 2'd2,
    REQ_WITHDRAW     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_UNLINK,
    FSM_ALLOC,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    req_e                   req_type;
    logic [PERSON_ID_W-1:0] person_id;
    logic                   is_preferential;
  } in_word_t;

  typedef struct packed {
    status_e                status;
    logic [PERSON_ID_W-1:0] served_id;
    logic                   served_preferential;
    logic [COUNT_W-1:0]     total_count;
    logic [COUNT_W-1:0]     preferential_count;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/two_class_priority_queue.sv @@
// two-class priority queue: linked arrival order over a slot store, walked by a sequencer
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | in_word_i  (request, id, preferential flag)
//   out     | output    | out_valid_o/out_stall_i | out_word_o (status, served entry, counts)
//
// one request at a time; an insert or withdraw walks the arrival list one entry per
//   cycle through the slot memory read port
// serve-oldest unlinks the head; serve-preferential walks to the first preferential entry
// reset clears the list pointers, counts and free-slot bookkeeping; slot memories need no clear
// in_stall_o is high from acceptance until the result word moves into the output register
// the output register lets a new request in while the previous word waits on out_stall_i
`default_nettype none

module two_class_priority_queue #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_BITS  = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire tcpq_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output tcpq_pkg::out_word_t       out_word_o
);

  import tcpq_pkg::*;

  // slot index, count and stored id widths
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SID_W = (ID_BITS < PERSON_ID_W) ? ID_BITS : PERSON_ID_W;

  // sequencer state
  fsm_e state_q, state_d;

  // latched request
  req_e             req_q, req_d;
  logic [SID_W-1:0] id_q, id_d;
  logic             pref_in_q, pref_in_d;

  // walk position
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic             has_prev_q, has_prev_d;
  logic [CNT_W-1:0] step_q, step_d;

  // list bookkeeping
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;

  // free slots: a stack of released slots plus a count of slots used so far
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;

  // result of the current request
  status_e          status_q, status_d;
  logic [SID_W-1:0] srv_id_q, srv_id_d;
  logic             srv_pref_q, srv_pref_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  // slot memories: {id, flag} and the next-slot link share one read address
  logic [SID_W:0]   data_mem [CAPACITY];
  logic [IDX_W-1:0] link_mem [CAPACITY];
  logic [IDX_W-1:0] free_mem [CAPACITY];

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [SID_W:0]   data_rd_q;
  logic [IDX_W-1:0] link_rd_q;
  logic [IDX_W-1:0] free_rd_q;

  logic             dt_we;
  logic [IDX_W-1:0] dt_waddr;
  logic             lk_we;
  logic [IDX_W-1:0] lk_waddr;
  logic [IDX_W-1:0] lk_wdata;
  logic             fr_we;

  // shared decisions
  logic             accept;
  logic             empty;
  logic             full;
  logic             walk_hit;
  logic             walk_last;
  logic             can_load;
  logic [SID_W-1:0] rd_id;
  logic             rd_pref;
  logic [IDX_W-1:0] sp_top;
  logic [IDX_W-1:0] new_slot;

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign empty       = (total_q == '0);
  assign full        = (total_q == CNT_W'(CAPACITY));
  assign rd_id       = data_rd_q[SID_W:1];
  assign rd_pref     = data_rd_q[0];
  // the preferential search is the only walk that matches on the flag
  assign walk_hit    = (req_q == REQ_SERVE_PREF) ? rd_pref : (rd_id == id_q);
  assign walk_last   = (step_q == (total_q - CNT_W'(1)));
  assign can_load    = !out_valid_q || !out_stall_i;
  assign sp_top      = IDX_W'(sp_q - CNT_W'(1));
  // reuse a released slot first, otherwise the next never-used one
  assign new_slot    = (sp_q != '0) ? free_rd_q : fresh_q[IDX_W-1:0];
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          case (in_word_i.req_type)
            REQ_INSERT:       state_d = empty ? FSM_ALLOC : FSM_WALK;
            REQ_SERVE_PREF: begin
              if (empty) begin
                state_d = FSM_DONE;
              end else if (pcnt_q != '0) begin
                state_d = FSM_WALK;
              end else begin
                state_d = FSM_UNLINK;
              end
            end
            REQ_SERVE_OLDEST: state_d = empty ? FSM_DONE : FSM_UNLINK;
            REQ_WITHDRAW:     state_d = empty ? FSM_DONE : FSM_WALK;
            default:          state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_WALK: begin
        if (walk_hit) begin
          state_d = (req_q == REQ_INSERT) ? FSM_DONE : FSM_UNLINK;
        end else if (walk_last) begin
          case (req_q)
            REQ_INSERT:     state_d = FSM_ALLOC;
            REQ_SERVE_PREF: state_d = FSM_UNLINK;
            default:        state_d = FSM_DONE;
          endcase
        end
      end
      FSM_UNLINK: state_d = FSM_DONE;
      FSM_ALLOC:  state_d = FSM_DONE;
      FSM_DONE: begin
        if (can_load) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    id_d        = id_q;
    pref_in_d   = pref_in_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    has_prev_d  = has_prev_q;
    step_d      = step_q;
    head_d      = head_q;
    tail_d      = tail_q;
    total_d     = total_q;
    pcnt_d      = pcnt_q;
    sp_d        = sp_q;
    fresh_d     = fresh_q;
    status_d    = status_q;
    srv_id_d    = srv_id_q;
    srv_pref_d  = srv_pref_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    dt_we       = 1'b0;
    dt_waddr    = new_slot;
    lk_we       = 1'b0;
    lk_waddr    = tail_q;
    lk_wdata    = new_slot;
    fr_we       = 1'b0;

    // output word leaves once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          req_d      = in_word_i.req_type;
          id_d       = in_word_i.person_id[SID_W-1:0];
          pref_in_d  = in_word_i.is_preferential;
          cur_d      = head_q;
          prev_d     = '0;
          has_prev_d = 1'b0;
          step_d     = '0;
          srv_id_d   = '0;
          srv_pref_d = 1'b0;
          status_d   = STAT_OK;
          // fetch the head entry right away
          rd_en      = 1'b1;
          rd_addr    = head_q;
          if (empty) begin
            case (in_word_i.req_type)
              REQ_SERVE_PREF,
              REQ_SERVE_OLDEST: status_d = STAT_EMPTY;
              REQ_WITHDRAW:     status_d = STAT_NOT_FOUND;
              default:          status_d = STAT_OK;
            endcase
          end
        end
      end
      FSM_WALK: begin
        if (walk_hit) begin
          // read data stays put for the unlink step
          if (req_q == REQ_INSERT) begin
            status_d = STAT_DUPLICATE;
          end
        end else if (walk_last) begin
          case (req_q)
            REQ_SERVE_PREF: begin
              // no preferential entry found: fall back to the oldest one
              cur_d      = head_q;
              prev_d     = '0;
              has_prev_d = 1'b0;
              rd_en      = 1'b1;
              rd_addr    = head_q;
            end
            REQ_WITHDRAW: status_d = STAT_NOT_FOUND;
            default:      status_d = status_q;
          endcase
        end else begin
          // follow the link straight from the read data
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          cur_d      = link_rd_q;
          step_d     = step_q + CNT_W'(1);
          rd_en      = 1'b1;
          rd_addr    = link_rd_q;
        end
      end
      FSM_UNLINK: begin
        if (req_q != REQ_WITHDRAW) begin
          srv_id_d   = rd_id;
          srv_pref_d = rd_pref;
        end
        if (!has_prev_q) begin
          head_d = link_rd_q;
        end else begin
          lk_we    = 1'b1;
          lk_waddr = prev_q;
          lk_wdata = link_rd_q;
        end
        if (cur_q == tail_q) begin
          tail_d = prev_q;
        end
        total_d = total_q - CNT_W'(1);
        if (rd_pref) begin
          pcnt_d = pcnt_q - CNT_W'(1);
        end
        // release the slot
        fr_we = 1'b1;
        sp_d  = sp_q + CNT_W'(1);
      end
      FSM_ALLOC: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          dt_we = 1'b1;
          if (empty) begin
            head_d = new_slot;
          end else begin
            lk_we = 1'b1;
          end
          tail_d  = new_slot;
          total_d = total_q + CNT_W'(1);
          pcnt_d  = pcnt_q + {{(CNT_W-1){1'b0}}, pref_in_q};
          if (sp_q != '0) begin
            sp_d = sp_q - CNT_W'(1);
          end else begin
            fresh_d = fresh_q + CNT_W'(1);
          end
        end
      end
      FSM_DONE: begin
        if (can_load) begin
          out_valid_d                    = 1'b1;
          out_word_d.status              = status_q;
          out_word_d.served_id           = PERSON_ID_W'(srv_id_q);
          out_word_d.served_preferential = srv_pref_q;
          out_word_d.total_count         = COUNT_W'(total_q);
          out_word_d.preferential_count  = COUNT_W'(pcnt_q);
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      pcnt_q      <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      pcnt_q      <= pcnt_d;
      sp_q        <= sp_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    id_q       <= id_d;
    pref_in_q  <= pref_in_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    has_prev_q <= has_prev_d;
    step_q     <= step_d;
    status_q   <= status_d;
    srv_id_q   <= srv_id_d;
    srv_pref_q <= srv_pref_d;
    out_word_q <= out_word_d;
  end

  // slot data memory
  always_ff @(posedge clk_i) begin
    if (dt_we) begin
      data_mem[dt_waddr] <= {id_q, pref_in_q};
    end
    if (rd_en) begin
      data_rd_q <= data_mem[rd_addr];
    end
  end

  // slot link memory
  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr];
    end
  end

  // released-slot stack, top of stack read every cycle
  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      free_mem[sp_q[IDX_W-1:0]] <= cur_q;
    end
    free_rd_q <= free_mem[sp_top];
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_pref_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= total_q)
    else $error("preferential count exceeds entry count");

  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, total_q} + {1'b0, sp_q}) == {1'b0, fresh_q})
    else $error("held plus released slots differ from slots ever used");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != FSM_IDLE) && in_stall_o)
    else $error("sequencer idle right after taking a request");
`endif

endmodule

`default_nettype wire
